>>> rtl/pbm_pkg.sv
// Package: shared types, mode codes and divide-by-255 helper for the pixel blender.
package pbm_pkg;

  localparam int NUM_COLOR = 3;
  localparam int NUM_CHAN  = 4;
  localparam int ALPHA_IDX = 3;

  localparam logic [7:0] CH_MAX = 8'd255;

  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_MULTIPLY = 2'd1;
  localparam logic [1:0] MODE_SCREEN   = 2'd2;

  typedef struct packed {
    logic [NUM_CHAN-1:0][7:0] base;
    logic [NUM_CHAN-1:0][7:0] top;
    logic [7:0]               weight;
  } mix_req_t;

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return sum[15:8];
  endfunction

endpackage

>>> rtl/pbm_in_if.sv
// Interface: input channel carrying a destination and a source RGBA pixel.
interface pbm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] dst_red;
  logic [7:0] dst_green;
  logic [7:0] dst_blue;
  logic [7:0] dst_alpha;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] src_alpha;

  modport source (
    output valid, dst_red, dst_green, dst_blue, dst_alpha,
    output src_red, src_green, src_blue, src_alpha,
    input  ready
  );

  modport sink (
    input  valid, dst_red, dst_green, dst_blue, dst_alpha,
    input  src_red, src_green, src_blue, src_alpha,
    output ready
  );
endinterface

>>> rtl/pbm_out_if.sv
// Interface: output channel carrying one blended RGBA pixel.
interface pbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

>>> rtl/pixel_blend_modes_top.sv
// Top level: RGBA pixel blender with normal, multiply and screen modes.
//
// pix_in carries one destination and one source RGBA pixel (8 bits per
// channel) per transaction; pix_out carries one blended pixel per
// transaction, in input order. Both use valid/ready.
// cfg_wr_en/cfg_wr_data write the 2-bit blend mode: 0 normal, 1 multiply,
// 2 screen; 3 acts as normal. Write it only while the pipeline is empty.
// Pipeline: an accepted pixel passes through the registered stages for
// products, top/base, interpolation products, and divide and sum into
// the output register before it is shown on pix_out.
// Throughput: one pixel per clock while the receiver holds ready high; every stage is fully pipelined.
// Reset (rst, synchronous) empties the pipeline and sets normal mode.
// When the receiver holds ready low the output register keeps its pixel;
// each stage with a free slot still advances, so up to four pixels are
// held before pix_in.ready drops.
module pixel_blend_modes_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  pbm_in_if.sink     pix_in,
  pbm_out_if.source  pix_out
);
  import pbm_pkg::*;

  logic [1:0] blend_mode;
  logic       mid_valid;
  logic       mid_ready;
  mix_req_t   mid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_NORMAL;
    end else if (cfg_wr_en) begin
      blend_mode <= cfg_wr_data;
    end
  end

  pbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mode      (blend_mode),
    .pix_in    (pix_in),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  pbm_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mid_valid),
    .in_ready (mid_ready),
    .in_data  (mid_data),
    .pix_out  (pix_out)
  );
endmodule

>>> rtl/pbm_front.sv
// Front stages: mode products, then top and base pixel formation.
module pbm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        mode,
  pbm_in_if.sink            pix_in,
  output logic              out_valid,
  input  logic              out_ready,
  output pbm_pkg::mix_req_t out_data
);
  import pbm_pkg::*;

  logic [7:0] dst_c [NUM_COLOR];
  logic [7:0] src_c [NUM_COLOR];

  // stage A
  logic        a_valid;
  logic        a_ready;
  logic [1:0]  a_mode;
  logic [15:0] a_mul [NUM_COLOR];
  logic [15:0] a_scr [NUM_COLOR];
  logic [15:0] a_bs  [NUM_COLOR];
  logic [15:0] a_bd  [NUM_COLOR];
  logic [7:0]  a_dst [NUM_COLOR];
  logic [7:0]  a_src [NUM_COLOR];
  logic [7:0]  a_top_alpha;
  logic [7:0]  a_base_alpha;
  logic [7:0]  a_weight;

  logic [8:0]  alpha_sum;
  logic [7:0]  top_alpha_next;
  logic [7:0]  base_alpha_next;

  // stage B
  logic     b_valid;
  logic     b_ready;
  mix_req_t b_data;
  mix_req_t b_data_next;

  assign dst_c[0] = pix_in.dst_red;
  assign dst_c[1] = pix_in.dst_green;
  assign dst_c[2] = pix_in.dst_blue;
  assign src_c[0] = pix_in.src_red;
  assign src_c[1] = pix_in.src_green;
  assign src_c[2] = pix_in.src_blue;

  assign b_ready      = !b_valid || out_ready;
  assign a_ready      = !a_valid || b_ready;
  assign pix_in.ready = a_ready;

  assign alpha_sum      = {1'b0, pix_in.dst_alpha} + {1'b0, pix_in.src_alpha};
  assign top_alpha_next = alpha_sum[8] ? CH_MAX : alpha_sum[7:0];

  always_comb begin
    if (mode == MODE_SCREEN && pix_in.src_alpha > pix_in.dst_alpha) begin
      base_alpha_next = pix_in.src_alpha;
    end else begin
      base_alpha_next = pix_in.dst_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pix_in.valid;
    end
    if (a_ready && pix_in.valid) begin
      a_mode       <= mode;
      a_top_alpha  <= top_alpha_next;
      a_base_alpha <= base_alpha_next;
      a_weight     <= pix_in.src_alpha;
      for (int i = 0; i < NUM_COLOR; i++) begin
        a_mul[i] <= 16'(dst_c[i]) * 16'(src_c[i]);
        a_scr[i] <= 16'(CH_MAX - dst_c[i]) * 16'(CH_MAX - src_c[i]);
        a_bs[i]  <= 16'(src_c[i]) * 16'(CH_MAX - pix_in.dst_alpha);
        a_bd[i]  <= 16'(dst_c[i]) * 16'(pix_in.dst_alpha);
        a_dst[i] <= dst_c[i];
        a_src[i] <= src_c[i];
      end
    end
  end

  always_comb begin
    b_data_next                 = '0;
    b_data_next.weight          = a_weight;
    b_data_next.top[ALPHA_IDX]  = a_top_alpha;
    b_data_next.base[ALPHA_IDX] = a_base_alpha;
    for (int i = 0; i < NUM_COLOR; i++) begin
      case (a_mode)
        MODE_MULTIPLY: begin
          b_data_next.top[i]  = div255(a_mul[i]);
          b_data_next.base[i] = a_dst[i];
        end
        MODE_SCREEN: begin
          b_data_next.top[i]  = CH_MAX - div255(a_scr[i]);
          b_data_next.base[i] = div255(a_bs[i]) + div255(a_bd[i]);
        end
        default: begin
          b_data_next.top[i]  = a_src[i];
          b_data_next.base[i] = a_dst[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_data <= b_data_next;
    end
  end

  assign out_valid = b_valid;
  assign out_data  = b_data;

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> a_valid)
    else $error("accepted transaction did not enter stage A");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_ready |=> a_valid && $stable(a_weight) && $stable(a_mode))
    else $error("stage A lost or changed a stalled transaction");

  b_advance: assert property (@(posedge clk) disable iff (rst)
    a_valid && b_ready |=> b_valid)
    else $error("stage B did not take stage A transaction");
endmodule

>>> rtl/pbm_mix.sv
// Mix stages: interpolation from base toward top by the source alpha.
module pbm_mix (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbm_pkg::mix_req_t in_data,
  pbm_out_if.source         pix_out
);
  import pbm_pkg::*;

  // stage C
  logic        c_valid;
  logic        c_ready;
  logic [15:0] c_pb [NUM_CHAN];
  logic [15:0] c_pt [NUM_CHAN];

  // stage D, output register
  logic       d_valid;
  logic       d_ready;
  logic [7:0] d_pix [NUM_CHAN];

  assign d_ready  = !d_valid || pix_out.ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= in_valid;
    end
    if (c_ready && in_valid) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        c_pb[i] <= 16'(in_data.base[i]) * 16'(CH_MAX - in_data.weight);
        c_pt[i] <= 16'(in_data.top[i]) * 16'(in_data.weight);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= c_valid;
    end
    if (d_ready && c_valid) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        d_pix[i] <= div255(c_pb[i]) + div255(c_pt[i]);
      end
    end
  end

  assign pix_out.valid     = d_valid;
  assign pix_out.out_red   = d_pix[0];
  assign pix_out.out_green = d_pix[1];
  assign pix_out.out_blue  = d_pix[2];
  assign pix_out.out_alpha = d_pix[ALPHA_IDX];

  c_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> c_valid)
    else $error("accepted transaction did not enter stage C");

  d_advance: assert property (@(posedge clk) disable iff (rst)
    c_valid && d_ready |=> d_valid)
    else $error("output register did not take stage C transaction");

  d_stall_holds: assert property (@(posedge clk) disable iff (rst)
    d_valid && !pix_out.ready |=> d_valid && $stable(d_pix[0]) && $stable(d_pix[ALPHA_IDX]))
    else $error("output register lost or changed a stalled transaction");
endmodule
